// ----- rtl/core/slip_frame_decoder_top_macros.svh -----
// ----------------------------------------------------------------------------
// slip_frame_decoder_top_macros.svh
// Assertion helpers used by the SLIP decoder RTL (sfd_decode).
// ----------------------------------------------------------------------------
`ifndef SLIP_FRAME_DECODER_TOP_MACROS_SVH
`define SLIP_FRAME_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types for the SLIP frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam int unsigned LEN_W = 12;

  localparam logic [LEN_W-1:0] MAX_FRAME = LEN_W'(2048);
  localparam logic [LEN_W-1:0] MIN_FRAME = LEN_W'(1);

  // SLIP special characters
  localparam logic [7:0] SLIP_END     = 8'o300;
  localparam logic [7:0] SLIP_ESC     = 8'o333;
  localparam logic [7:0] SLIP_ESC_END = 8'o334;
  localparam logic [7:0] SLIP_ESC_ESC = 8'o335;

  // result kind codes
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  typedef struct packed {
    logic             emit;
    logic             kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] frame_length;
    logic             overflow;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/sfd_rx_if.sv -----
// ----------------------------------------------------------------------------
// sfd_rx_if
// Valid/ready channel carrying one raw serial byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sfd_res_if.sv -----
// ----------------------------------------------------------------------------
// sfd_res_if
// Valid/ready channel carrying one decoded result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfd_res_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [7:0]                data_byte;
  logic [sfd_pkg::LEN_W-1:0] frame_length;
  logic                      overflow;

  modport source (output valid, output kind, output data_byte, output frame_length,
                  output overflow, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_length,
                  input overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sfd_decode.sv -----
// ----------------------------------------------------------------------------
// sfd_decode
// SLIP deframing state and per-byte decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "slip_frame_decoder_top_macros.svh"

module sfd_decode (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      fire_i,
  input  wire logic [7:0]                byte_i,
  input  wire logic [sfd_pkg::LEN_W-1:0] limit_i,
  output sfd_pkg::result_t               res_o
);

  logic                      started_q, started_d;
  logic                      esc_q, esc_d;
  logic [sfd_pkg::LEN_W-1:0] count_q, count_d;
  logic                      ovf_q, ovf_d;
  logic [7:0]                mapped;
  logic                      take;

  always_comb begin
    started_d = started_q;
    esc_d     = esc_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    take      = 1'b0;
    mapped    = byte_i;
    res_o     = '0;

    if (!started_q) begin
      if (byte_i == sfd_pkg::SLIP_END) begin
        started_d = 1'b1;
      end
    end else if (esc_q) begin
      esc_d = 1'b0;
      take  = 1'b1;
      if (byte_i == sfd_pkg::SLIP_ESC_END) begin
        mapped = sfd_pkg::SLIP_END;
      end else if (byte_i == sfd_pkg::SLIP_ESC_ESC) begin
        mapped = sfd_pkg::SLIP_ESC;
      end
    end else if (byte_i == sfd_pkg::SLIP_END) begin
      // empty frames are skipped
      if (count_q != '0) begin
        res_o.emit         = 1'b1;
        res_o.kind         = sfd_pkg::KIND_EOF;
        res_o.frame_length = count_q;
        res_o.overflow     = ovf_q;
        started_d          = 1'b0;
        count_d            = '0;
        ovf_d              = 1'b0;
      end
    end else if (byte_i == sfd_pkg::SLIP_ESC) begin
      esc_d = 1'b1;
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (count_q >= limit_i) begin
        ovf_d = 1'b1;
      end else begin
        count_d         = count_q + sfd_pkg::LEN_W'(1);
        res_o.emit      = 1'b1;
        res_o.kind      = sfd_pkg::KIND_DATA;
        res_o.data_byte = mapped;
        res_o.overflow  = ovf_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      esc_q     <= 1'b0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
    end else if (fire_i) begin
      started_q <= started_d;
      esc_q     <= esc_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
    end
  end

  `SFD_ASSERT_NOW(a_esc_started, clk_i, rst_ni, esc_q, started_q, "escape armed while waiting")
  `SFD_ASSERT_NOW(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= sfd_pkg::MAX_FRAME, "count over cap")
  `SFD_ASSERT_NOW(a_eof_len, clk_i, rst_ni, res_o.emit && res_o.kind == sfd_pkg::KIND_EOF, res_o.frame_length != '0, "empty frame closed")
  `SFD_ASSERT_NEXT(a_eof_clear, clk_i, rst_ni, fire_i && res_o.emit && res_o.kind == sfd_pkg::KIND_EOF, !started_q && count_q == '0 && !ovf_q, "frame state not cleared")

endmodule

`default_nettype wire

// ----- rtl/core/sfd_out_reg.sv -----
// ----------------------------------------------------------------------------
// sfd_out_reg
// Result register holding one beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_out_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire sfd_pkg::result_t res_i,
  output logic            free_o,
  sfd_res_if.source       res_o
);

  logic                      valid_q;
  logic                      kind_q;
  logic [7:0]                data_q;
  logic [sfd_pkg::LEN_W-1:0] len_q;
  logic                      ovf_q;

  // a slot opens when empty or when the held beat leaves this cycle
  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      kind_q <= res_i.kind;
      data_q <= res_i.data_byte;
      len_q  <= res_i.frame_length;
      ovf_q  <= res_i.overflow;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.kind         = kind_q;
  assign res_o.data_byte    = data_q;
  assign res_o.frame_length = len_q;
  assign res_o.overflow     = ovf_q;

endmodule

`default_nettype wire

// ----- rtl/core/slip_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// slip_frame_decoder_top
// SLIP receive deframer: raw serial bytes in, decoded bytes and frame ends out.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i  : one raw link byte per beat (valid/ready).
//   res_o : one result per beat; kind 0 carries a decoded data byte, kind 1
//           marks end of frame with its length and the overflow flag.
//   cfg   : cfg_we_i writes max_length from cfg_wdata_i; 0 acts as 1, values
//           above 2048 saturate. Write only while the block is idle.
// Path: an accepted byte is held in the input register, decoded, and loaded
//   into the result register, from which res_o is driven.
// Throughput: one byte per cycle while res_o is not held, set by the single
//   input-to-result stage; bytes that make no result (framing, escapes,
//   drops) keep that rate even while res_o is held.
// Reset: waits for a first END; limit returns to 2048; both stages empty.
// Stall: while res_o is held, a byte that makes a result waits in the input
//   register and rx_i.ready drops; bytes that make no result still drain.
// ----------------------------------------------------------------------------
`default_nettype none

module slip_frame_decoder_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [sfd_pkg::LEN_W-1:0] cfg_wdata_i,
  sfd_rx_if.sink                         rx_i,
  sfd_res_if.source                      res_o
);

  logic                      in_valid_q;
  logic [7:0]                in_byte_q;
  logic [sfd_pkg::LEN_W-1:0] limit_q, limit_d;
  sfd_pkg::result_t          res;
  logic                      out_free;
  logic                      fire;

  // clamp the limit once, at write time
  always_comb begin
    if (cfg_wdata_i == '0) begin
      limit_d = sfd_pkg::MIN_FRAME;
    end else if (cfg_wdata_i > sfd_pkg::MAX_FRAME) begin
      limit_d = sfd_pkg::MAX_FRAME;
    end else begin
      limit_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= sfd_pkg::MAX_FRAME;
    end else if (cfg_we_i) begin
      limit_q <= limit_d;
    end
  end

  // held byte retires when it needs no slot or the result slot is free
  assign fire       = in_valid_q && (!res.emit || out_free);
  assign rx_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  sfd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte_q),
    .limit_i (limit_q),
    .res_o   (res)
  );

  sfd_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire && res.emit),
    .res_i  (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

// ----- tb/slip_frame_decoder_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slip_frame_decoder_top_tb
// Self-checking bench for the SLIP receive deframer. Raw link bytes go in on
// the rx channel, and every result beat is checked against a cycle-free
// decoder model kept in the bench or a result typed into the short table of
// hand-written bytes that comes first. After it come phases of random frames
// under different length limits, random stalls on both channels in all but one.
// ----------------------------------------------------------------------------

module slip_frame_decoder_top_tb;
  import sfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000; // generous: worst gaps on every beat
  localparam int unsigned SETTLE_CYCLES = 4;      // two-stage pipe plus margin
  localparam int unsigned PHASE_BYTES   = 50;     // in-frame bytes per random phase
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned MAX_REPORTS   = 10;

  // one result beat as seen on res_o
  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] frame_length;
    logic             overflow;
  } decoded_t;

  localparam decoded_t NO_EV = '0;

  // how a table row is checked
  typedef enum logic [1:0] {
    CHK_PREDICT,  // use the bench decoder
    CHK_SILENT,   // no result expected
    CHK_TYPED     // result written out in the row
  } row_check_e;

  typedef struct packed {
    logic [7:0]       rx;
    logic             set_lim;  // drain and write max_length before this byte
    logic [LEN_W-1:0] lim;
    row_check_e       chk;
    decoded_t         ev;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // Directed bytes. Limit is 2048 out of reset until the row that sets it to 1.
  // --------------------------------------------------------------------------
  stim_row_t dir_rows [25] = '{
    // waiting for the opening END: everything is dropped, ESC too
    '{8'h00,        1'b0, 12'd0, CHK_SILENT, NO_EV},
    '{SLIP_ESC,     1'b0, 12'd0, CHK_SILENT, NO_EV},
    '{SLIP_END,     1'b0, 12'd0, CHK_SILENT, NO_EV},
    // END with nothing stored is skipped
    '{SLIP_END,     1'b0, 12'd0, CHK_SILENT, NO_EV},
    '{8'h00,        1'b0, 12'd0, CHK_TYPED, '{KIND_DATA, 8'h00, 12'd0, 1'b0}},
    '{8'hFF,        1'b0, 12'd0, CHK_TYPED, '{KIND_DATA, 8'hFF, 12'd0, 1'b0}},
    // escape pairs map back to END and ESC
    '{SLIP_ESC,     1'b0, 12'd0, CHK_SILENT, NO_EV},
    '{SLIP_ESC_END, 1'b0, 12'd0, CHK_TYPED, '{KIND_DATA, SLIP_END, 12'd0, 1'b0}},
    '{SLIP_ESC,     1'b0, 12'd0, CHK_SILENT, NO_EV},
    '{SLIP_ESC_ESC, 1'b0, 12'd0, CHK_TYPED, '{KIND_DATA, SLIP_ESC, 12'd0, 1'b0}},
    // any other escaped byte passes as it is
    '{SLIP_ESC,     1'b0, 12'd0, CHK_SILENT, NO_EV},
    '{8'h41,        1'b0, 12'd0, CHK_TYPED, '{KIND_DATA, 8'h41, 12'd0, 1'b0}},
    // escaped END is data and leaves the frame open
    '{SLIP_ESC,     1'b0, 12'd0, CHK_SILENT, NO_EV},
    '{SLIP_END,     1'b0, 12'd0, CHK_TYPED, '{KIND_DATA, SLIP_END, 12'd0, 1'b0}},
    '{SLIP_ESC,     1'b0, 12'd0, CHK_SILENT, NO_EV},
    '{SLIP_ESC,     1'b0, 12'd0, CHK_TYPED, '{KIND_DATA, SLIP_ESC, 12'd0, 1'b0}},
    // bare ESC_END outside an escape is plain data
    '{SLIP_ESC_END, 1'b0, 12'd0, CHK_TYPED, '{KIND_DATA, SLIP_ESC_END, 12'd0, 1'b0}},
    '{SLIP_END,     1'b0, 12'd0, CHK_TYPED, '{KIND_EOF, 8'h00, 12'd8, 1'b0}},
    // back to waiting after the frame
    '{8'h12,        1'b0, 12'd0, CHK_SILENT, NO_EV},
    // limit of one: second byte overflows, closing END carries the flag
    '{SLIP_END,     1'b1, 12'd1, CHK_SILENT, NO_EV},
    '{8'h01,        1'b0, 12'd0, CHK_TYPED, '{KIND_DATA, 8'h01, 12'd0, 1'b0}},
    '{8'h02,        1'b0, 12'd0, CHK_SILENT, NO_EV},
    '{SLIP_ESC,     1'b0, 12'd0, CHK_PREDICT, NO_EV},
    '{SLIP_ESC_END, 1'b0, 12'd0, CHK_PREDICT, NO_EV},
    '{SLIP_END,     1'b0, 12'd0, CHK_TYPED, '{KIND_EOF, 8'h00, 12'd1, 1'b1}}
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  sfd_rx_if  rx_if ();
  sfd_res_if res_if ();

  slip_frame_decoder_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench decoder state, mirrors the block's frame tracking.
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] limit_reg   = MAX_FRAME;
  bit               in_frame    = 1'b0;
  bit               esc_armed   = 1'b0;
  logic [LEN_W-1:0] kept_cnt    = '0;
  bit               dropped_any = 1'b0;

  decoded_t    decoded_q [$];   // results still owed by the block, oldest first
  int unsigned mismatches = 0;
  int unsigned bytes_used = 0;  // accepted bytes that met an open frame
  int unsigned cycles     = 0;
  bit          steady     = 1'b0; // no idling on either side while set

  // Store one decoded byte if the frame has room, else note the overflow.
  function automatic bit keep_byte(input logic [7:0] b, output decoded_t ev);
    logic [LEN_W-1:0] lim;
    lim = limit_reg;
    if (lim == '0) lim = MIN_FRAME;
    if (lim > MAX_FRAME) lim = MAX_FRAME;
    ev = NO_EV;
    if (kept_cnt >= lim) begin
      dropped_any = 1'b1;
      return 1'b0;
    end
    kept_cnt       = kept_cnt + 1'b1;
    ev.kind        = KIND_DATA;
    ev.data_byte   = b;
    ev.overflow    = dropped_any;
    return 1'b1;
  endfunction

  // Advance the decoder by one link byte; returns 1 when a result is due.
  function automatic bit slip_decode(input logic [7:0] raw, output decoded_t ev);
    logic [7:0] b;
    b  = raw;
    ev = NO_EV;
    if (!in_frame) begin
      if (b == SLIP_END) in_frame = 1'b1;
      return 1'b0;
    end
    if (esc_armed) begin
      esc_armed = 1'b0;
      if (b == SLIP_ESC_END) b = SLIP_END;
      else if (b == SLIP_ESC_ESC) b = SLIP_ESC;
      return keep_byte(b, ev);
    end
    if (b == SLIP_END) begin
      if (kept_cnt == '0) return 1'b0;
      ev.kind         = KIND_EOF;
      ev.frame_length = kept_cnt;
      ev.overflow     = dropped_any;
      in_frame        = 1'b0;
      kept_cnt        = '0;
      dropped_any     = 1'b0;
      return 1'b1;
    end
    if (b == SLIP_ESC) begin
      esc_armed = 1'b1;
      return 1'b0;
    end
    return keep_byte(b, ev);
  endfunction

  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic report(input string what, input decoded_t want, input decoded_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: exp kind=%0d data=%02h len=%0d ovf=%0d, got kind=%0d data=%02h len=%0d ovf=%0d",
               $time, what, want.kind, want.data_byte, want.frame_length, want.overflow,
               got.kind, got.data_byte, got.frame_length, got.overflow);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check every beat against the oldest owed result.
  // Sampling at the edge sees pre-edge values of the block's registers.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : res_check
    decoded_t got;
    decoded_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = '{res_if.kind, res_if.data_byte, res_if.frame_length, res_if.overflow};
      if (decoded_q.size() == 0) begin
        report("beat with nothing owed", NO_EV, got);
      end else begin
        want = decoded_q.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.frame_length !== want.frame_length || got.overflow !== want.overflow)
          report("result mismatch", want, got);
      end
    end
  end

  // Result side back-pressure: bursts of ready with random stalls between.
  initial begin : res_stall
    int unsigned n;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = gap_len();
      if (n != 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("slip_frame_decoder_top_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Send one byte after a random gap. Valid is only dropped when a gap is
  // taken, so back-to-back beats never see a low/high pair in one step.
  // The decoder runs at the accepting edge; typed and silent rows override its result.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input row_check_e chk, input decoded_t typed_ev);
    int unsigned n;
    bit          was_open;
    bit          made;
    decoded_t    ev;
    n = gap_len();
    if (n != 0) begin
      rx_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    was_open = in_frame;
    made     = slip_decode(b, ev);
    if (chk == CHK_SILENT) made = 1'b0;
    if (chk == CHK_TYPED) begin
      made = 1'b1;
      ev   = typed_ev;
    end
    if (made) decoded_q.push_back(ev);
    if (was_open) bytes_used++;
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_byte(b, CHK_PREDICT, NO_EV);
  endtask

  // Hold the sender until every owed beat is out, then let the pipe empty.
  task automatic settle();
    rx_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg  = v;
  endtask

  // One payload byte worth of link traffic, escapes weighted up.
  task automatic send_token();
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    if (r < 10) begin
      send_plain(SLIP_ESC);
      send_plain(SLIP_ESC_END);
    end else if (r < 18) begin
      send_plain(SLIP_ESC);
      send_plain(SLIP_ESC_ESC);
    end else if (r < 22) begin
      // escaped arbitrary byte, END now and then
      send_plain(SLIP_ESC);
      send_plain(b);
    end else if (r < 30) begin
      case (r % 4)
        0: send_plain(SLIP_ESC_END);
        1: send_plain(SLIP_ESC_ESC);
        2: send_plain(8'h00);
        default: send_plain(8'hFF);
      endcase
    end else if (b == SLIP_END) begin
      send_plain(SLIP_ESC);
      send_plain(SLIP_ESC_END);
    end else if (b == SLIP_ESC) begin
      send_plain(SLIP_ESC);
      send_plain(SLIP_ESC_ESC);
    end else begin
      send_plain(b);
    end
  endtask

  // A whole frame, sometimes with line noise ahead or a dangling ESC that
  // eats the closing END and runs the frame into the next one.
  task automatic send_frame(input int unsigned n_tokens);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) repeat ($urandom_range(1, 3)) send_plain(8'($urandom_range(0, 255)));
    send_plain(SLIP_END);
    repeat (n_tokens) send_token();
    if (r >= 94) send_plain(SLIP_ESC);
    send_plain(SLIP_END);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [LEN_W-1:0] phase_lim;
    int unsigned      phase_start;
    bit               paused;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    paused        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_lim) begin
        settle();
        write_limit(dir_rows[i].lim);
      end
      send_byte(dir_rows[i].rx, dir_rows[i].chk, dir_rows[i].ev);
    end

    // Random phases: limit 0 (acts as 1), 4095 (saturates to the ceiling),
    // a small limit, 2048 with no idling, a random small limit, and one
    // under the ceiling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: phase_lim = '0;
        1: phase_lim = '1;
        2: phase_lim = 12'd5;
        3: phase_lim = MAX_FRAME;
        4: phase_lim = LEN_W'($urandom_range(1, 20));
        default: phase_lim = MAX_FRAME - 1'b1;
      endcase
      write_limit(phase_lim);
      steady = (p == 3);
      phase_start = bytes_used;
      while (bytes_used - phase_start < PHASE_BYTES) begin
        send_frame(($urandom_range(0, 99) < 85) ? $urandom_range(0, 10)
                                                : $urandom_range(11, 40));
        // mid-phase hold: sender waits for the result side to catch up
        if (p == 2 && !paused && bytes_used - phase_start >= PHASE_BYTES / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("slip_frame_decoder_top_tb: PASS");
    end else begin
      $display("slip_frame_decoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule
